FILE: hw/rtl/dq_pkg.sv
package dq_pkg;

    localparam int KIND_W = 3;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 2;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [KIND_W-1:0]       t_kind;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [ST_W-1:0]         t_status;

    localparam t_kind K_PUSH_FRONT = 3'd0;
    localparam t_kind K_PUSH_BACK  = 3'd1;
    localparam t_kind K_POP_FRONT  = 3'd2;
    localparam t_kind K_POP_BACK   = 3'd3;
    localparam t_kind K_DUMP_FWD   = 3'd4;
    localparam t_kind K_DUMP_REV   = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_ONE   = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

endpackage

FILE: hw/rtl/dq_if.sv
interface dq_in_if;
    logic           valid;
    logic           ready;
    dq_pkg::t_kind  kind;
    dq_pkg::t_value value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

interface dq_out_if;
    logic            valid;
    logic            ready;
    dq_pkg::t_value  item_value;
    dq_pkg::t_value  front_value;
    dq_pkg::t_value  back_value;
    dq_pkg::t_count  entry_count;
    dq_pkg::t_status status;
    logic            last;

    modport source (output valid, output item_value, output front_value, output back_value,
                    output entry_count, output status, output last, input ready);
    modport sink (input valid, input item_value, input front_value, input back_value,
                  input entry_count, input status, input last, output ready);
endinterface

FILE: hw/rtl/dq_ram.sv
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/double_ended_queue.sv
// push, refused and unknown operations: result valid in the cycle after the input transfer
// pops: one store read, registered read data captured in the wait state, then the result is valid
// dumps: each entry is read the same way; the next read starts only once the output takes an entry
// next input is taken the cycle after the final result transfer; pops and dumps share the single
// store read port
// reset (synchronous, active low) empties the queue and idles the sequencer; store kept
module double_ended_queue #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dq_in_if.sink     i_req,
    dq_out_if.source  o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = dq_pkg::CNT_W;
    localparam int VAL_WIDTH = dq_pkg::VAL_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WAIT = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        M_POPF = 2'd0,
        M_POPB = 2'd1,
        M_FWD  = 2'd2,
        M_REV  = 2'd3
    } t_mode;

    t_state          r_state, n_state;
    t_mode           r_mode, n_mode;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    dq_pkg::t_value  r_front_val, n_front_val;
    dq_pkg::t_value  r_back_val, n_back_val;
    dq_pkg::t_value  r_item, n_item;
    dq_pkg::t_status r_status, n_status;
    logic            r_last, n_last;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic                  re;
    logic [AW-1:0]         raddr;
    logic [VAL_WIDTH-1:0]  rdata;

    // slot of front plus offset, offset below DEPTH
    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    dq_ram #(
        .WIDTH (VAL_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_req.value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_front_val = r_front_val;
        n_back_val  = r_back_val;
        n_item      = r_item;
        n_status    = r_status;
        n_last      = r_last;
        we          = 1'b0;
        waddr       = r_front;
        re          = 1'b0;
        raddr       = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_item   = '0;
                    n_last   = 1'b1;
                    n_status = dq_pkg::ST_OK;
                    n_state  = S_OUT;
                    unique case (i_req.kind)
                        dq_pkg::K_PUSH_FRONT, dq_pkg::K_PUSH_BACK: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = dq_pkg::ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_req.kind == dq_pkg::K_PUSH_FRONT) begin
                                    n_front     = (r_front == '0) ? AW'(DEPTH - 1)
                                                                  : r_front - AW'(1);
                                    waddr       = n_front;
                                    n_front_val = i_req.value;
                                    if (r_count == '0) begin
                                        n_back_val = i_req.value;
                                    end
                                end else begin
                                    waddr      = f_wrap(r_front, r_count);
                                    n_back_val = i_req.value;
                                    if (r_count == '0) begin
                                        n_front_val = i_req.value;
                                    end
                                end
                            end
                        end
                        dq_pkg::K_POP_FRONT, dq_pkg::K_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = dq_pkg::ST_EMPTY;
                            end else if (r_count == CW'(1)) begin
                                n_status = dq_pkg::ST_ONE;
                            end else begin
                                // refetch the new end of the queue
                                n_count = r_count - CW'(1);
                                re      = 1'b1;
                                n_state = S_WAIT;
                                if (i_req.kind == dq_pkg::K_POP_FRONT) begin
                                    n_mode  = M_POPF;
                                    n_front = f_wrap(r_front, CW'(1));
                                    raddr   = n_front;
                                end else begin
                                    n_mode = M_POPB;
                                    raddr  = f_wrap(r_front, r_count - CW'(2));
                                end
                            end
                        end
                        dq_pkg::K_DUMP_FWD, dq_pkg::K_DUMP_REV: begin
                            if (r_count == '0) begin
                                n_status = dq_pkg::ST_EMPTY;
                            end else begin
                                re      = 1'b1;
                                n_idx   = '0;
                                n_state = S_WAIT;
                                if (i_req.kind == dq_pkg::K_DUMP_FWD) begin
                                    n_mode = M_FWD;
                                    raddr  = f_wrap(r_front, '0);
                                end else begin
                                    n_mode = M_REV;
                                    raddr  = f_wrap(r_front, r_count - CW'(1));
                                end
                            end
                        end
                        default: begin
                            n_status = dq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                n_state  = S_OUT;
                n_status = dq_pkg::ST_OK;
                unique case (r_mode)
                    M_POPF: begin
                        n_front_val = rdata;
                        n_item      = '0;
                        n_last      = 1'b1;
                    end
                    M_POPB: begin
                        n_back_val = rdata;
                        n_item     = '0;
                        n_last     = 1'b1;
                    end
                    M_FWD, M_REV: begin
                        n_item = rdata;
                        n_last = (r_idx == r_count - CW'(1));
                    end
                    default: begin
                        n_item = '0;
                    end
                endcase
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    if (!r_last) begin
                        // next dump entry
                        n_idx   = r_idx + CW'(1);
                        re      = 1'b1;
                        n_state = S_WAIT;
                        if (r_mode == M_FWD) begin
                            raddr = f_wrap(r_front, r_idx + CW'(1));
                        end else begin
                            raddr = f_wrap(r_front, r_count - CW'(2) - r_idx);
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_POPF;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_front_val <= n_front_val;
        r_back_val  <= n_back_val;
        r_item      <= n_item;
        r_status    <= n_status;
        r_last      <= n_last;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_OUT);
    assign o_rsp.item_value  = r_item;
    assign o_rsp.front_value = (r_count == '0) ? '0 : r_front_val;
    assign o_rsp.back_value  = (r_count == '0) ? '0 : r_back_val;
    assign o_rsp.entry_count = r_count;
    assign o_rsp.status      = r_status;
    assign o_rsp.last        = r_last;

endmodule

FILE: hw/rtl/dq_checker.sv
module dq_checker #(
    parameter int DEPTH = 64
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input dq_pkg::t_value  i_item_value,
    input dq_pkg::t_count  i_entry_count,
    input dq_pkg::t_status i_status,
    input logic            i_last
);

    // one item at a time: no new transfer right after one is taken
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an item is in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_entry_count <= dq_pkg::CNT_W'(DEPTH)))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == dq_pkg::ST_FULL) |->
            (i_entry_count == dq_pkg::CNT_W'(DEPTH) && i_last))
        else $error("full status with room left");

    a_refused_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == dq_pkg::ST_ONE || i_status == dq_pkg::ST_EMPTY)) |->
            (i_last && i_item_value == '0 &&
             ((i_status == dq_pkg::ST_ONE) ? (i_entry_count == dq_pkg::CNT_W'(1))
                                           : (i_entry_count == '0))))
        else $error("refused status inconsistent with count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_item_value) && $stable(i_last)))
        else $error("stalled result changed");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_item_value  (o_rsp.item_value),
    .i_entry_count (o_rsp.entry_count),
    .i_status      (o_rsp.status),
    .i_last        (o_rsp.last)
);

FILE: test/deque_check.sv
`timescale 1ns / 100ps

module deque_check #(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dq_in_if     i_req,
    dq_out_if    i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_results,
    output int   o_full_seen
);

    typedef struct {
        dq_pkg::t_value  item_value;
        dq_pkg::t_value  front_value;
        dq_pkg::t_value  back_value;
        dq_pkg::t_count  entry_count;
        dq_pkg::t_status status;
        logic            last;
    } t_result;

    dq_pkg::t_value slots [DEPTH];
    int             head_idx = 0;
    int             held = 0;
    t_result        due_results[$];
    int             err_count = 0;
    int             result_count = 0;
    int             full_count = 0;

    // front and back are sampled from the state after the operation
    function automatic void queue_result(dq_pkg::t_value item, dq_pkg::t_status status,
                                         logic last);
        t_result r;
        r.item_value  = item;
        r.front_value = (held != 0) ? slots[head_idx] : '0;
        r.back_value  = (held != 0) ? slots[(head_idx + held - 1) % DEPTH] : '0;
        r.entry_count = dq_pkg::t_count'(held);
        r.status      = status;
        r.last        = last;
        due_results.push_back(r);
    endfunction

    function automatic void deque_apply(dq_pkg::t_kind kind, dq_pkg::t_value value);
        int off;
        case (kind)
            dq_pkg::K_PUSH_FRONT, dq_pkg::K_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    full_count++;
                    queue_result('0, dq_pkg::ST_FULL, 1'b1);
                end else begin
                    if (kind == dq_pkg::K_PUSH_FRONT) begin
                        head_idx = (head_idx + DEPTH - 1) % DEPTH;
                        slots[head_idx] = value;
                    end else begin
                        slots[(head_idx + held) % DEPTH] = value;
                    end
                    held++;
                    queue_result('0, dq_pkg::ST_OK, 1'b1);
                end
            end
            dq_pkg::K_POP_FRONT, dq_pkg::K_POP_BACK: begin
                if (held == 0) begin
                    queue_result('0, dq_pkg::ST_EMPTY, 1'b1);
                end else if (held == 1) begin
                    // the last entry is never removed
                    queue_result('0, dq_pkg::ST_ONE, 1'b1);
                end else begin
                    if (kind == dq_pkg::K_POP_FRONT)
                        head_idx = (head_idx + 1) % DEPTH;
                    held--;
                    queue_result('0, dq_pkg::ST_OK, 1'b1);
                end
            end
            dq_pkg::K_DUMP_FWD, dq_pkg::K_DUMP_REV: begin
                if (held == 0) begin
                    queue_result('0, dq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < held; i++) begin
                        off = (kind == dq_pkg::K_DUMP_FWD) ? i : held - 1 - i;
                        queue_result(slots[(head_idx + off) % DEPTH], dq_pkg::ST_OK,
                                     i == held - 1);
                    end
                end
            end
            default: queue_result('0, dq_pkg::ST_OK, 1'b1);
        endcase
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= 40)
                $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                         $time, name, want, got);
        end
    endfunction

    function automatic void check_result();
        t_result want;
        result_count++;
        if (due_results.size() == 0) begin
            err_count++;
            if (err_count <= 40)
                $display("%0t: unexpected result transfer, expected none, actual item 0x%08h",
                         $time, i_rsp.item_value);
        end else begin
            want = due_results.pop_front();
            compare_field("item_value", want.item_value, i_rsp.item_value);
            compare_field("front_value", want.front_value, i_rsp.front_value);
            compare_field("back_value", want.back_value, i_rsp.back_value);
            compare_field("entry_count", 32'(want.entry_count), 32'(i_rsp.entry_count));
            compare_field("status", 32'(want.status), 32'(i_rsp.status));
            compare_field("last", 32'(want.last), 32'(i_rsp.last));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_idx = 0;
            held = 0;
            due_results.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                deque_apply(i_req.kind, i_req.value);
            if (i_rsp.valid && i_rsp.ready)
                check_result();
        end
        o_pending   <= due_results.size();
        o_errors    <= err_count;
        o_results   <= result_count;
        o_full_seen <= full_count;
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int            DEPTH      = 64;
    localparam int            CYCLE_LIMIT = 4_000_000;
    localparam int            RAND_ITEMS = 200;
    localparam dq_pkg::t_kind K_SPARE_6  = 3'd6;
    localparam dq_pkg::t_kind K_SPARE_7  = 3'd7;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dq_in_if  req_if ();
    dq_out_if rsp_if ();

    int errors;
    int pending;
    int results;
    int full_seen;

    int cycle_count = 0;
    int stall_left = 0;
    bit steady = 1'b0;
    int level = 0;
    int n_push = 0;
    int n_pop = 0;
    int n_dump = 0;
    int n_other = 0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    deque_check #(
        .DEPTH(DEPTH)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_full_seen (full_seen)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic dq_pkg::t_value pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        int gap;
        gap = pick_gap();
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= gap - 1;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // valid stays high from one transfer to the next when there is no gap
    task automatic send_op(dq_pkg::t_kind kind, dq_pkg::t_value value);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind  <= kind;
        req_if.value <= value;
        do @(posedge i_clk); while (!req_if.ready);
        case (kind)
            dq_pkg::K_PUSH_FRONT, dq_pkg::K_PUSH_BACK: begin
                n_push++;
                if (level < DEPTH)
                    level++;
            end
            dq_pkg::K_POP_FRONT, dq_pkg::K_POP_BACK: begin
                n_pop++;
                if (level > 1)
                    level--;
            end
            dq_pkg::K_DUMP_FWD, dq_pkg::K_DUMP_REV: n_dump++;
            default: n_other++;
        endcase
    endtask

    initial begin
        t_phase        phase;
        int            at_edge;
        int            mix_left;
        int            r;
        dq_pkg::t_kind kind;

        req_if.valid <= 1'b0;
        req_if.kind  <= dq_pkg::K_PUSH_FRONT;
        req_if.value <= '0;
        i_rst_n      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, spare kinds, single entry, extreme values
        send_op(dq_pkg::K_POP_FRONT, 32'h1234_5678);
        send_op(dq_pkg::K_POP_BACK, '1);
        send_op(dq_pkg::K_DUMP_FWD, '0);
        send_op(dq_pkg::K_DUMP_REV, '0);
        send_op(K_SPARE_6, '1);
        send_op(K_SPARE_7, '0);
        send_op(dq_pkg::K_PUSH_BACK, 32'h7fff_ffff);
        send_op(dq_pkg::K_POP_FRONT, '0);
        send_op(dq_pkg::K_POP_BACK, '0);
        send_op(dq_pkg::K_DUMP_FWD, '0);
        send_op(dq_pkg::K_DUMP_REV, '0);
        send_op(dq_pkg::K_PUSH_FRONT, 32'h8000_0000);
        send_op(dq_pkg::K_PUSH_BACK, '0);
        send_op(dq_pkg::K_PUSH_FRONT, '1);
        send_op(dq_pkg::K_DUMP_FWD, '0);
        send_op(dq_pkg::K_DUMP_REV, '0);
        send_op(dq_pkg::K_POP_FRONT, '1);
        send_op(dq_pkg::K_POP_BACK, '1);
        send_op(K_SPARE_6, 32'h5555_5555);
        send_op(dq_pkg::K_PUSH_BACK, 32'h5555_5555);
        send_op(dq_pkg::K_PUSH_FRONT, 32'haaaa_aaaa);
        send_op(K_SPARE_7, 32'haaaa_aaaa);
        send_op(dq_pkg::K_DUMP_REV, '0);

        // fill to the top, drain to one entry, then mixed traffic
        phase = PH_FILL;
        at_edge = 0;
        mix_left = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            case (phase)
                PH_FILL: begin
                    if (r < 85)
                        kind = dq_pkg::t_kind'($urandom_range(0, 1));
                    else if (r < 95)
                        kind = dq_pkg::t_kind'($urandom_range(4, 5));
                    else
                        kind = dq_pkg::t_kind'($urandom_range(2, 7));
                end
                PH_DRAIN: begin
                    if (r < 85)
                        kind = dq_pkg::t_kind'($urandom_range(2, 3));
                    else if (r < 93)
                        kind = dq_pkg::t_kind'($urandom_range(0, 1));
                    else
                        kind = dq_pkg::t_kind'($urandom_range(4, 7));
                end
                default: kind = dq_pkg::t_kind'($urandom_range(0, 7));
            endcase
            send_op(kind, pick_value());

            case (phase)
                PH_FILL: begin
                    if (level == DEPTH && ++at_edge >= 4) begin
                        phase = PH_DRAIN;
                        at_edge = 0;
                        steady = ($urandom_range(0, 3) == 0);
                    end
                end
                PH_DRAIN: begin
                    if (level <= 1 && ++at_edge >= 3) begin
                        phase = PH_MIX;
                        at_edge = 0;
                        mix_left = $urandom_range(20, 40);
                        steady = ($urandom_range(0, 3) == 0);
                    end
                end
                default: begin
                    if (--mix_left <= 0) begin
                        phase = PH_FILL;
                        steady = ($urandom_range(0, 3) == 0);
                    end
                end
            endcase
        end

        req_if.valid <= 1'b0;
        steady = 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("sent %0d operations: %0d pushes, %0d pops, %0d dumps, %0d spare kinds",
                 n_push + n_pop + n_dump + n_other, n_push, n_pop, n_dump, n_other);
        $display("checked %0d results, %0d pushes refused on a full queue", results, full_seen);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: double_ended_queue.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_if.sv
hw/rtl/dq_ram.sv
hw/rtl/double_ended_queue.sv
hw/rtl/dq_checker.sv
test/deque_check.sv
test/testbench.sv
